/* design/assert_macros.svh */
// Assertion macros shared by the line box downscaler RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off during reset.
`define LBD_ASSERT_IMPL(label, clk_sig, rst_n_sig, ante, cons) \
	label: assert property (@(posedge clk_sig) disable iff (!rst_n_sig) (ante) |-> (cons)) \
	else $error("line box downscaler: same-cycle check failed");

// Next-cycle implication, held off during reset.
`define LBD_ASSERT_NEXT(label, clk_sig, rst_n_sig, ante, cons) \
	label: assert property (@(posedge clk_sig) disable iff (!rst_n_sig) (ante) |=> (cons)) \
	else $error("line box downscaler: next-cycle check failed");

`endif

/* design/lbd_pkg.sv */
// Shared constants and controller/datapath types for the line box downscaler.
package lbd_pkg;

	// Default values for the top-level parameters
	localparam int PIXEL_BITS_DEF    = 16;
	localparam int FRAC_BITS_DEF     = 8;
	localparam int MAX_OUT_WIDTH_DEF = 4096;

	// Fixed field and register widths
	localparam int PIX_W       = 16;
	localparam int COORD_W     = 16;
	localparam int OUT_WIDTH_W = 13;
	localparam int CFG_DATA_W  = 16;
	localparam int CFG_IDX_W   = 2;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_START_X   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ZOOM_STEP = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_OUT_WIDTH = 2'd2;

	// Register reset values
	localparam logic [COORD_W-1:0]     START_X_RESET   = 16'd0;
	localparam logic [COORD_W-1:0]     ZOOM_STEP_RESET = 16'd256;
	localparam logic [OUT_WIDTH_W-1:0] OUT_WIDTH_RESET = 13'd512;

	// Commands from controller to datapath
	typedef struct packed {
		logic capture;   // take the input item
		logic open;      // latch line settings
		logic add;       // add pixel into the window sum if it lies inside
		logic div_start; // start the window mean division
		logic emit;      // load the output register and advance
		logic finish;    // advance the input index, close line on line_end
		logic phase;     // 0: limit is the index, 1: index plus one
	} lbd_cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic line_open;
		logic avg_mode;
		logic emit_cond;
		logic nonempty;
		logic div_done;
		logic out_free;
	} lbd_stat_t;

endpackage

/* design/lbd_in_if.sv */
// Input pixel channel: valid/ready handshake with one line pixel per item.
interface lbd_in_if;
	import lbd_pkg::*;

	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] in_pixel;
	logic             line_end;

	modport source (output valid, output in_pixel, output line_end, input ready);
	modport sink   (input valid, input in_pixel, input line_end, output ready);
endinterface

/* design/lbd_out_if.sv */
// Output pixel channel: valid/ready handshake with one resampled pixel per item.
interface lbd_out_if;
	import lbd_pkg::*;

	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] out_pixel;
	logic             empty_window;
	logic             last_out;

	modport source (output valid, output out_pixel, output empty_window, output last_out,
		input ready);
	modport sink   (input valid, input out_pixel, input empty_window, input last_out,
		output ready);
endinterface

/* design/line_box_downscaler_unit.sv */
// Top level of the line box downscaler: controller, datapath and checks.
//
// Resamples one image line to out_width pixels. With a step below 1.5 each
// output copies the input pixel at floor(start_x + 0.5 + k*step); with a larger
// step each output is the truncated mean of the inputs since the previous window
// end. Input items are taken one at a time: each item is accepted, then checked
// against the window end, in averaging mode both before and after the pixel is
// added; the first pixel of a line first latches the line settings, and each
// result passes through the emit step, for a non-empty averaging window after the
// mean divider, which yields one quotient bit per cycle. Results wait in a single
// output register; while it is full and not taken, the next result holds the
// sequencer. Registers written mid-line take effect at the next line.
`include "assert_macros.svh"

module line_box_downscaler_unit #(
	parameter int PIXEL_BITS    = lbd_pkg::PIXEL_BITS_DEF,
	parameter int FRAC_BITS     = lbd_pkg::FRAC_BITS_DEF,
	parameter int MAX_OUT_WIDTH = lbd_pkg::MAX_OUT_WIDTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_write_en,
	input  logic [lbd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [lbd_pkg::CFG_DATA_W-1:0] cfg_data,
	lbd_in_if.sink                         line_pixels,
	lbd_out_if.source                      scaled_pixels
);
	import lbd_pkg::*;

	lbd_cmd_t  cmd;
	lbd_stat_t stat;
	logic      ctrl_ready;

	// Sequencer
	lbd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (line_pixels.valid),
		.in_ready (ctrl_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	assign line_pixels.ready = ctrl_ready;

	// Datapath
	lbd_dpath #(
		.PIXEL_BITS    (PIXEL_BITS),
		.FRAC_BITS     (FRAC_BITS),
		.MAX_OUT_WIDTH (MAX_OUT_WIDTH)
	) u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_write_en  (cfg_write_en),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_pixel      (line_pixels.in_pixel),
		.line_end      (line_pixels.line_end),
		.cmd           (cmd),
		.stat          (stat),
		.scaled_pixels (scaled_pixels)
	);

	// Checks
	`LBD_ASSERT_IMPL(a_emit_slot_free, clk, arst_n, cmd.emit, stat.out_free)
	`LBD_ASSERT_IMPL(a_div_nonempty, clk, arst_n, cmd.div_start, stat.avg_mode && stat.nonempty)
	`LBD_ASSERT_NEXT(a_div_busy, clk, arst_n, cmd.div_start, !stat.div_done)
	`LBD_ASSERT_IMPL(a_ready_quiet, clk, arst_n, line_pixels.ready, !cmd.emit && stat.div_done)
endmodule

/* design/lbd_div.sv */
// Restoring divider, one quotient bit per cycle, for the window mean.
module lbd_div #(
	parameter int NUM_BITS = 24,
	parameter int DEN_BITS = 9
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [NUM_BITS-1:0] dividend,
	input  logic [DEN_BITS-1:0] divisor,
	output logic                done,
	output logic [NUM_BITS-1:0] quotient
);
	localparam int ITER_BITS = $clog2(NUM_BITS + 1);

	logic [ITER_BITS-1:0] iter_q;
	logic [NUM_BITS-1:0]  quo_q;
	logic [DEN_BITS-1:0]  rem_q;
	logic [DEN_BITS-1:0]  den_q;
	logic [DEN_BITS:0]    trial;
	logic [DEN_BITS:0]    diff;
	logic                 fits;

	// Trial subtraction of the shifted partial remainder
	always_comb begin
		trial = {rem_q, quo_q[NUM_BITS-1]};
		diff  = trial - {1'b0, den_q};
		fits  = trial >= {1'b0, den_q};
	end

	// Iteration counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iter_q <= '0;
		end else if (start) begin
			iter_q <= ITER_BITS'(NUM_BITS);
		end else if (iter_q != '0) begin
			iter_q <= iter_q - ITER_BITS'(1);
		end
	end

	// Dividend shifts out as quotient bits shift in
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			den_q <= divisor;
		end else if (iter_q != '0) begin
			quo_q <= {quo_q[NUM_BITS-2:0], fits};
			rem_q <= fits ? diff[DEN_BITS-1:0] : trial[DEN_BITS-1:0];
		end
	end

	assign done     = (iter_q == '0);
	assign quotient = quo_q;
endmodule

/* design/lbd_ctrl.sv */
// Sequencer for the line box downscaler: one input item at a time.
module lbd_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  lbd_pkg::lbd_stat_t stat,
	output lbd_pkg::lbd_cmd_t  cmd
);
	import lbd_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_OPEN = 3'd1;
	localparam logic [2:0] ST_TEST = 3'd2;
	localparam logic [2:0] ST_DIV  = 3'd3;
	localparam logic [2:0] ST_EMIT = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       phase_q;
	logic       phase_d;

	// Next state and commands
	always_comb begin
		state_d   = state_q;
		phase_d   = phase_q;
		cmd       = '0;
		cmd.phase = phase_q;
		in_ready  = (state_q == ST_IDLE);
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					phase_d     = 1'b0;
					state_d     = stat.line_open ? ST_TEST : ST_OPEN;
				end
			end
			ST_OPEN: begin
				cmd.open = 1'b1;
				state_d  = ST_TEST;
			end
			ST_TEST: begin
				if (stat.emit_cond) begin
					if (stat.avg_mode && stat.nonempty) begin
						cmd.div_start = 1'b1;
						state_d       = ST_DIV;
					end else begin
						state_d = ST_EMIT;
					end
				end else if (stat.avg_mode && !phase_q) begin
					// sample goes into the window, then windows ending one later
					cmd.add = 1'b1;
					phase_d = 1'b1;
				end else begin
					cmd.finish = 1'b1;
					phase_d    = 1'b0;
					state_d    = ST_IDLE;
				end
			end
			ST_DIV: begin
				if (stat.div_done) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (stat.out_free) begin
					cmd.emit = 1'b1;
					state_d  = ST_TEST;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			phase_q <= 1'b0;
		end else begin
			state_q <= state_d;
			phase_q <= phase_d;
		end
	end
endmodule

/* design/lbd_dpath.sv */
// Datapath: registers, line state, position tracking, window sum and output register.
module lbd_dpath #(
	parameter int PIXEL_BITS    = lbd_pkg::PIXEL_BITS_DEF,
	parameter int FRAC_BITS     = lbd_pkg::FRAC_BITS_DEF,
	parameter int MAX_OUT_WIDTH = lbd_pkg::MAX_OUT_WIDTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_write_en,
	input  logic [lbd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [lbd_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic [lbd_pkg::PIX_W-1:0]      in_pixel,
	input  logic                           line_end,
	input  lbd_pkg::lbd_cmd_t              cmd,
	output lbd_pkg::lbd_stat_t             stat,
	lbd_out_if.source                      scaled_pixels
);
	import lbd_pkg::*;

	localparam int CNT_BITS = $clog2(MAX_OUT_WIDTH + 1);
	localparam int POS_BITS = FRAC_BITS + 17 + $clog2(MAX_OUT_WIDTH);
	localparam int INT_BITS = POS_BITS - FRAC_BITS;
	localparam int IDX_BITS = INT_BITS + 1;
	localparam int SUM_BITS = PIXEL_BITS + COORD_W - FRAC_BITS;
	localparam int DIV_BITS = COORD_W + 1 - FRAC_BITS;

	localparam logic [COORD_W-1:0]  MIN_STEP   = COORD_W'((1 << FRAC_BITS) >> 4);
	localparam logic [COORD_W:0]    AVG_THRESH = (COORD_W + 1)'(3 << (FRAC_BITS - 1));
	localparam logic [POS_BITS-1:0] HALF_STEP  = POS_BITS'(1) << (FRAC_BITS - 1);
	localparam logic [CNT_BITS-1:0] MAX_WIDTH  = CNT_BITS'(MAX_OUT_WIDTH);

	// Configuration registers
	logic [COORD_W-1:0]     start_x_q;
	logic [COORD_W-1:0]     zoom_step_q;
	logic [OUT_WIDTH_W-1:0] out_width_q;

	// Line state
	logic                  line_open_q;
	logic                  avg_q;
	logic [COORD_W-1:0]    step_q;
	logic [CNT_BITS-1:0]   width_q;
	logic [INT_BITS-1:0]   window_start_q;
	logic [POS_BITS-1:0]   next_pos_q;
	logic [SUM_BITS-1:0]   sum_q;
	logic [CNT_BITS-1:0]   count_q;
	logic [IDX_BITS-1:0]   index_q;

	// Current item
	logic [PIXEL_BITS-1:0] pixel_q;
	logic                  line_end_q;

	// Output register
	logic                  out_valid_q;
	logic [PIX_W-1:0]      out_pixel_q;
	logic                  empty_q;
	logic                  last_q;

	// Derived values
	logic [POS_BITS-1:0]   base;
	logic [POS_BITS-1:0]   base_back;
	logic [COORD_W-1:0]    open_step;
	logic [CNT_BITS-1:0]   open_width;
	logic                  open_avg;
	logic [INT_BITS-1:0]   open_wstart;
	logic [INT_BITS-1:0]   win_end;
	logic [IDX_BITS:0]     limit;
	logic                  count_room;
	logic                  nonempty;
	logic                  in_window;
	logic [DIV_BITS-1:0]   divisor;
	logic [SUM_BITS-1:0]   quotient;
	logic                  div_done;
	logic [PIXEL_BITS-1:0] emit_val;
	logic [CNT_BITS:0]     count_next;

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_x_q   <= START_X_RESET;
			zoom_step_q <= ZOOM_STEP_RESET;
			out_width_q <= OUT_WIDTH_RESET;
		end else if (cfg_write_en) begin
			case (cfg_index)
				REG_START_X:   start_x_q   <= cfg_data[COORD_W-1:0];
				REG_ZOOM_STEP: zoom_step_q <= cfg_data[COORD_W-1:0];
				REG_OUT_WIDTH: out_width_q <= cfg_data[OUT_WIDTH_W-1:0];
				default: ;
			endcase
		end
	end

	// Line settings taken at the first pixel
	always_comb begin
		base        = POS_BITS'(start_x_q) << FRAC_BITS;
		open_step   = (zoom_step_q < MIN_STEP) ? MIN_STEP : zoom_step_q;
		open_width  = (32'(out_width_q) > 32'(MAX_OUT_WIDTH)) ? MAX_WIDTH
			: CNT_BITS'(out_width_q);
		open_avg    = {1'b0, open_step} >= AVG_THRESH;
		base_back   = base - POS_BITS'(open_step);
		open_wstart = (base >= POS_BITS'(open_step)) ? base_back[POS_BITS-1:FRAC_BITS] : '0;
	end

	// Window end against the current limit
	always_comb begin
		win_end    = next_pos_q[POS_BITS-1:FRAC_BITS];
		limit      = {1'b0, index_q} + (IDX_BITS + 1)'(cmd.phase);
		count_room = count_q < width_q;
		nonempty   = win_end > window_start_q;
		in_window  = (IDX_BITS'(window_start_q) <= index_q) && count_room;
		divisor    = DIV_BITS'(win_end - window_start_q);
		count_next = {1'b0, count_q} + (CNT_BITS + 1)'(1);
		if (!avg_q) begin
			emit_val = pixel_q;
		end else if (nonempty) begin
			emit_val = PIXEL_BITS'(quotient);
		end else begin
			emit_val = '0;
		end
	end

	// Window mean
	lbd_div #(
		.NUM_BITS (SUM_BITS),
		.DEN_BITS (DIV_BITS)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (sum_q),
		.divisor  (divisor),
		.done     (div_done),
		.quotient (quotient)
	);

	// Item capture
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			pixel_q    <= PIXEL_BITS'(in_pixel);
			line_end_q <= line_end;
		end
	end

	// Line state updates
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_open_q    <= 1'b0;
			avg_q          <= 1'b0;
			step_q         <= MIN_STEP;
			width_q        <= '0;
			window_start_q <= '0;
			next_pos_q     <= '0;
			sum_q          <= '0;
			count_q        <= '0;
			index_q        <= '0;
		end else begin
			if (cmd.open) begin
				line_open_q    <= 1'b1;
				avg_q          <= open_avg;
				step_q         <= open_step;
				width_q        <= open_width;
				window_start_q <= open_avg ? open_wstart : '0;
				next_pos_q     <= open_avg ? base : base + HALF_STEP;
				sum_q          <= '0;
				count_q        <= '0;
				index_q        <= '0;
			end
			if (cmd.add && in_window) begin
				sum_q <= sum_q + SUM_BITS'(pixel_q);
			end
			if (cmd.emit) begin
				count_q    <= count_q + CNT_BITS'(1);
				next_pos_q <= next_pos_q + POS_BITS'(step_q);
				if (avg_q) begin
					sum_q <= '0;
					if (nonempty) begin
						window_start_q <= win_end;
					end
				end
			end
			if (cmd.finish) begin
				// index saturates on very long lines
				if (index_q != '1) begin
					index_q <= index_q + IDX_BITS'(1);
				end
				if (line_end_q) begin
					line_open_q    <= 1'b0;
					avg_q          <= 1'b0;
					step_q         <= MIN_STEP;
					width_q        <= '0;
					window_start_q <= '0;
					next_pos_q     <= '0;
					sum_q          <= '0;
					count_q        <= '0;
					index_q        <= '0;
				end
			end
		end
	end

	// Output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (scaled_pixels.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_pixel_q <= PIX_W'(emit_val);
			empty_q     <= avg_q && !nonempty;
			last_q      <= (count_next == {1'b0, width_q});
		end
	end

	assign scaled_pixels.valid        = out_valid_q;
	assign scaled_pixels.out_pixel    = out_pixel_q;
	assign scaled_pixels.empty_window = empty_q;
	assign scaled_pixels.last_out     = last_q;

	// Status
	always_comb begin
		stat           = '0;
		stat.line_open = line_open_q;
		stat.avg_mode  = avg_q;
		stat.emit_cond = count_room && ((IDX_BITS + 1)'(win_end) <= limit);
		stat.nonempty  = nonempty;
		stat.div_done  = div_done;
		stat.out_free  = !out_valid_q || scaled_pixels.ready;
	end
endmodule

/* tb/scaled_line_checker.sv */
// Checker for the line box downscaler: predicts every output item and compares it.
`timescale 1ns / 100ps

module scaled_line_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_write_en,
	input  logic [lbd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [lbd_pkg::CFG_DATA_W-1:0] cfg_data,
	lbd_in_if                              line_pixels,
	lbd_out_if                             scaled_pixels,
	output int                             failures,
	output int                             results_due
);
	import lbd_pkg::*;

	localparam int FRAC         = FRAC_BITS_DEF;
	localparam int HALF_STEP    = 1 << (FRAC - 1);
	localparam int AVG_STEP     = 3 << (FRAC - 1);
	localparam int MIN_STEP     = ((1 << FRAC) >> 4) > 0 ? ((1 << FRAC) >> 4) : 1;
	localparam int MAX_WIDTH    = MAX_OUT_WIDTH_DEF;
	localparam int MAX_PER_ITEM = 16;

	typedef struct packed {
		logic [PIX_W-1:0] out_pixel;
		logic             empty_window;
		logic             last_out;
	} scaled_item_t;

	scaled_item_t scaled_due_q[$];

	// Register copies
	logic [COORD_W-1:0]     reg_start_x;
	logic [COORD_W-1:0]     reg_zoom_step;
	logic [OUT_WIDTH_W-1:0] reg_out_width;

	// Line state
	bit          line_live;
	bit          avg_mode;
	logic [39:0] line_step;
	int          line_width;
	logic [31:0] pix_index;
	logic [39:0] win_sum;
	logic [39:0] win_start;
	logic [39:0] next_pos;
	int          made_count;
	int          made_now;

	task automatic close_line();
		line_live  = 1'b0;
		avg_mode   = 1'b0;
		line_step  = 40'(MIN_STEP);
		line_width = 0;
		pix_index  = '0;
		win_sum    = '0;
		win_start  = '0;
		next_pos   = '0;
		made_count = 0;
	endtask

	// Latch the settings at the first pixel of a line
	task automatic open_line_settings();
		logic [39:0] base;
		base       = {24'b0, reg_start_x} << FRAC;
		line_step  = (reg_zoom_step < 16'(MIN_STEP)) ? 40'(MIN_STEP) : 40'(reg_zoom_step);
		line_width = (reg_out_width > MAX_WIDTH) ? MAX_WIDTH : reg_out_width;
		avg_mode   = line_step >= AVG_STEP;
		if (avg_mode) begin
			next_pos  = base;
			win_start = (base >= line_step) ? (base - line_step) >> FRAC : '0;
		end else begin
			next_pos  = base + HALF_STEP;
			win_start = '0;
		end
		win_sum    = '0;
		pix_index  = '0;
		made_count = 0;
		line_live  = 1'b1;
	endtask

	task automatic emit_scaled(input logic [PIX_W-1:0] value, input logic empty);
		scaled_item_t item;
		item.out_pixel    = value;
		item.empty_window = empty;
		item.last_out     = (made_count + 1 == line_width);
		scaled_due_q.push_back(item);
		made_count++;
		made_now++;
	endtask

	// Close every averaging window that ends at or below the limit
	task automatic flush_windows(input logic [39:0] limit);
		logic [39:0] win_end;
		logic [39:0] quot;
		while (made_count < line_width && made_now < MAX_PER_ITEM &&
				(next_pos >> FRAC) <= limit) begin
			win_end = next_pos >> FRAC;
			if (win_end > win_start) begin
				quot = win_sum / (win_end - win_start);
				emit_scaled(quot[PIX_W-1:0], 1'b0);
				win_start = win_end;
			end else begin
				emit_scaled('0, 1'b1);
			end
			win_sum  = '0;
			next_pos = next_pos + line_step;
		end
	endtask

	task automatic predict_pixel(input logic [PIX_W-1:0] pix, input logic last);
		logic [39:0] idx;
		made_now = 0;
		if (!line_live)
			open_line_settings();
		idx = {8'b0, pix_index};
		if (avg_mode) begin
			flush_windows(idx);
			if (idx >= win_start && made_count < line_width)
				win_sum = win_sum + pix;
			flush_windows(idx + 1);
		end else begin
			while (made_count < line_width && made_now < MAX_PER_ITEM &&
					(next_pos >> FRAC) <= idx) begin
				emit_scaled(pix, 1'b0);
				next_pos = next_pos + line_step;
			end
		end
		if (pix_index != '1)
			pix_index = pix_index + 1;
		if (last)
			close_line();
	endtask

	task automatic check_result();
		scaled_item_t want;
		if (scaled_due_q.size() == 0) begin
			$error("unexpected item: out_pixel %0h empty_window %0b last_out %0b",
				scaled_pixels.out_pixel, scaled_pixels.empty_window, scaled_pixels.last_out);
			failures++;
		end else begin
			want = scaled_due_q.pop_front();
			if (scaled_pixels.out_pixel !== want.out_pixel) begin
				$error("out_pixel: expected %0h, got %0h", want.out_pixel,
					scaled_pixels.out_pixel);
				failures++;
			end
			if (scaled_pixels.empty_window !== want.empty_window) begin
				$error("empty_window: expected %0b, got %0b", want.empty_window,
					scaled_pixels.empty_window);
				failures++;
			end
			if (scaled_pixels.last_out !== want.last_out) begin
				$error("last_out: expected %0b, got %0b", want.last_out,
					scaled_pixels.last_out);
				failures++;
			end
		end
	endtask

	initial failures = 0;

	// Watch writes and both channels at every edge
	always @(posedge clk) begin
		if (!arst_n) begin
			reg_start_x   = START_X_RESET;
			reg_zoom_step = ZOOM_STEP_RESET;
			reg_out_width = OUT_WIDTH_RESET;
			close_line();
			scaled_due_q.delete();
			results_due <= 0;
		end else begin
			if (cfg_write_en) begin
				case (cfg_index)
					REG_START_X:   reg_start_x   = cfg_data;
					REG_ZOOM_STEP: reg_zoom_step = cfg_data;
					REG_OUT_WIDTH: reg_out_width = cfg_data[OUT_WIDTH_W-1:0];
					default: ;
				endcase
			end
			if (scaled_pixels.valid && scaled_pixels.ready)
				check_result();
			if (line_pixels.valid && line_pixels.ready)
				predict_pixel(line_pixels.in_pixel, line_pixels.line_end);
			results_due <= scaled_due_q.size();
		end
	end

endmodule

/* tb/testbench.sv */
// Top of the line box downscaler testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module testbench;
	import lbd_pkg::*;

	localparam int QUIET_LIMIT  = 2000;
	localparam int SETTLE_TICKS = 64;
	localparam int RANDOM_ITEMS = 135;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_write_en;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	int failures;
	int results_due;
	int pixels_sent;
	int quiet_ticks;
	bit send_burst;

	lbd_in_if  line_pixels();
	lbd_out_if scaled_pixels();

	line_box_downscaler_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_write_en  (cfg_write_en),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.line_pixels   (line_pixels),
		.scaled_pixels (scaled_pixels)
	);

	scaled_line_checker checker_i (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_write_en  (cfg_write_en),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.line_pixels   (line_pixels),
		.scaled_pixels (scaled_pixels),
		.failures      (failures),
		.results_due   (results_due)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Watchdog: too long with no item moving and no write
	always @(posedge clk) begin
		if (arst_n !== 1'b1 || cfg_write_en ||
				(line_pixels.valid && line_pixels.ready) ||
				(scaled_pixels.valid && scaled_pixels.ready)) begin
			quiet_ticks <= 0;
		end else if (quiet_ticks >= QUIET_LIMIT) begin
			$display("testbench: done, errors");
			$finish;
		end else begin
			quiet_ticks <= quiet_ticks + 1;
		end
	end

	// Output side: random stalls, with stretches of none
	initial begin
		int gap;
		int served;
		bit burst;
		served = 0;
		burst  = 1'b0;
		scaled_pixels.ready <= 1'b0;
		@(posedge clk);
		while (arst_n !== 1'b1) @(posedge clk);
		forever begin
			if (served % 24 == 0)
				burst = ($urandom_range(0, 2) == 0);
			gap = burst ? 0 : $urandom_range(0, 17);
			if (gap > 0) begin
				scaled_pixels.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			scaled_pixels.ready <= 1'b1;
			do @(posedge clk); while (!(scaled_pixels.valid && scaled_pixels.ready));
			served++;
		end
	end

	task automatic send_pixel(input logic [PIX_W-1:0] pix, input logic last);
		int gap;
		gap = send_burst ? 0 : $urandom_range(0, 17);
		if (gap > 0) begin
			line_pixels.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		line_pixels.valid    <= 1'b1;
		line_pixels.in_pixel <= pix;
		line_pixels.line_end <= last;
		do @(posedge clk); while (!(line_pixels.valid && line_pixels.ready));
		pixels_sent++;
	endtask

	// Hold the input until every predicted item has come out
	task automatic wait_drained();
		line_pixels.valid <= 1'b0;
		@(posedge clk);
		while (results_due != 0) @(posedge clk);
	endtask

	// Let the block go idle, then write all three registers
	task automatic load_settings(input logic [15:0] sx, input logic [15:0] zs,
			input logic [12:0] ow);
		wait_drained();
		repeat (SETTLE_TICKS) @(posedge clk);
		cfg_write_en <= 1'b1;
		cfg_index    <= REG_START_X;
		cfg_data     <= sx;
		@(posedge clk);
		cfg_index    <= REG_ZOOM_STEP;
		cfg_data     <= zs;
		@(posedge clk);
		cfg_index    <= REG_OUT_WIDTH;
		cfg_data     <= {3'b0, ow};
		@(posedge clk);
		cfg_write_en <= 1'b0;
	endtask

	function automatic logic [PIX_W-1:0] rand_pixel();
		case ($urandom_range(0, 9))
			0:       return '0;
			1:       return '1;
			default: return PIX_W'($urandom_range(0, 65535));
		endcase
	endfunction

	task automatic send_line(input int len, input bit closed);
		for (int k = 0; k < len; k++)
			send_pixel(rand_pixel(), closed && (k == len - 1));
	endtask

	initial begin
		logic [15:0] sx;
		logic [15:0] zs;
		logic [12:0] ow;
		int base_count;
		int nlines;
		pixels_sent  = 0;
		quiet_ticks  = 0;
		send_burst   = 1'b0;
		arst_n       <= 1'b0;
		cfg_write_en <= 1'b0;
		cfg_index    <= REG_START_X;
		cfg_data     <= '0;
		line_pixels.valid    <= 1'b0;
		line_pixels.in_pixel <= '0;
		line_pixels.line_end <= 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: plain copy, line shorter than the width
		send_pixel(16'h0000, 1'b0);
		send_pixel(16'hFFFF, 1'b0);
		send_pixel(16'h8000, 1'b0);
		send_pixel(16'h0001, 1'b1);

		// Averaging from start 0: empty first window, then a longer line than needed
		load_settings(16'd0, 16'd512, 13'd3);
		send_pixel(16'hFFFF, 1'b0);
		send_pixel(16'hFFFE, 1'b0);
		send_pixel(16'h0000, 1'b0);
		send_pixel(16'h0001, 1'b0);
		wait_drained();
		send_pixel(rand_pixel(), 1'b0);
		send_pixel(rand_pixel(), 1'b0);
		send_pixel(rand_pixel(), 1'b0);
		send_pixel(rand_pixel(), 1'b1);

		// Step below the minimum: up to sixteen items per pixel, cut short by line end
		load_settings(16'd1, 16'd0, 13'd40);
		send_pixel(16'h1234, 1'b0);
		send_pixel(16'hFFFF, 1'b0);
		send_pixel(16'h0000, 1'b1);

		// Zero width at the far extremes: nothing comes out
		load_settings(16'hFFFF, 16'hFFFF, 13'd0);
		send_pixel(16'hFFFF, 1'b0);
		send_pixel(16'h0000, 1'b1);

		// Width above the maximum at the minimum step
		load_settings(16'd0, 16'd16, 13'h1FFF);
		send_pixel(16'hA5A5, 1'b0);
		send_pixel(16'h5A5A, 1'b1);

		// Step exactly at the averaging threshold; first pixel before the window
		load_settings(16'd3, 16'd384, 13'd4);
		for (int k = 0; k < 5; k++)
			send_pixel(rand_pixel(), k == 4);

		// Random phases: mostly well-formed lines, some left open
		base_count = pixels_sent;
		while (pixels_sent - base_count < RANDOM_ITEMS) begin
			case ($urandom_range(0, 9))
				0:       zs = 16'($urandom_range(0, 15));
				1:       zs = 16'hFFFF;
				2:       zs = $urandom_range(0, 1) ? 16'd383 : 16'd384;
				3:       zs = 16'($urandom_range(0, 65535));
				4, 5, 6: zs = 16'($urandom_range(16, 383));
				default: zs = 16'($urandom_range(384, 1100));
			endcase
			case ($urandom_range(0, 7))
				0:       sx = 16'd0;
				1:       sx = 16'hFFFF;
				2:       sx = 16'($urandom_range(0, 65535));
				default: sx = 16'($urandom_range(0, 12));
			endcase
			case ($urandom_range(0, 9))
				0:       ow = 13'd0;
				1:       ow = 13'd4096;
				2:       ow = 13'h1FFF;
				3:       ow = 13'($urandom_range(4097, 8191));
				default: ow = 13'($urandom_range(1, 40));
			endcase
			load_settings(sx, zs, ow);
			nlines = $urandom_range(1, 3);
			for (int l = 0; l < nlines; l++) begin
				send_burst = ($urandom_range(0, 3) == 0);
				send_line($urandom_range(1, 24), $urandom_range(0, 5) != 0);
			end
			send_burst = 1'b0;
		end

		// Drain, then allow the last pixel to finish inside the block
		wait_drained();
		repeat (SETTLE_TICKS) @(posedge clk);
		if (failures == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

endmodule

/* files.f */
+incdir+design
design/lbd_pkg.sv
design/lbd_in_if.sv
design/lbd_out_if.sv
design/lbd_div.sv
design/lbd_ctrl.sv
design/lbd_dpath.sv
design/line_box_downscaler_unit.sv
tb/scaled_line_checker.sv
tb/testbench.sv
